FILE: rtl/owlarb_pkg.sv
`default_nettype none

package owlarb_pkg;

  localparam int MAX_LOCKS  = 64;
  localparam int NODE_SLOTS = 16;

  localparam int KIND_W    = 1;
  localparam int LOCK_ID_W = 6;
  localparam int NODE_ID_W = 4;
  localparam int STATE_W   = 2;
  localparam int SEQ_W     = 32;
  localparam int NIU_W     = 5;

  localparam logic [NIU_W-1:0] NIU_RESET = NIU_W'(16);

  localparam int ROW_W  = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
  localparam int LANE_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  // Candidate lanes for the reduction, padded up to a power of two.
  localparam int CAND_N = 1 << LANE_W;
  localparam int LVL_W  = (LANE_W > 1) ? $clog2(LANE_W) : 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [STATE_W-1:0] ST_IDLE    = 2'd0;
  localparam logic [STATE_W-1:0] ST_WAITING = 2'd1;
  localparam logic [STATE_W-1:0] ST_LOCKED  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;

  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_WRITE = 2'd1,
    OP_ARB   = 2'd2
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [ROW_W-1:0]       row;
    logic [LANE_W-1:0]      lane;
    logic [STATE_W-1:0]     new_state;
    logic [SEQ_W-1:0]       seq;
    logic [NODE_SLOTS-1:0]  span;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

`default_nettype wire

FILE: rtl/owlarb_front.sv
`default_nettype none

module owlarb_front import owlarb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [LOCK_ID_W-1:0] lock_id_i,
  input  logic [NODE_ID_W-1:0] node_id_i,
  input  logic [STATE_W-1:0]   new_state_i,
  input  logic [SEQ_W-1:0]     seq_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [NIU_W-1:0]     cfg_nodes_in_use_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output item_t                item_o
);

  logic [NIU_W-1:0] niu_q, niu_d;
  logic             lock_ok;
  logic             node_ok;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    niu_d = niu_q;
    if (cfg_valid_i) begin
      niu_d = cfg_nodes_in_use_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      niu_q <= NIU_RESET;
    end else begin
      niu_q <= niu_d;
    end
  end

  assign lock_ok = 32'(lock_id_i) < 32'(MAX_LOCKS);
  assign node_ok = 32'(node_id_i) < 32'(NODE_SLOTS);

  always_comb begin
    item_o.row       = ROW_W'(lock_id_i);
    item_o.lane      = LANE_W'(node_id_i);
    item_o.new_state = new_state_i;
    item_o.seq       = seq_i;
    // Lanes past the configured node count are masked out; a count above
    // the table width saturates naturally since no lane lies beyond it.
    for (int i = 0; i < NODE_SLOTS; i++) begin
      item_o.span[i] = 32'(i) < 32'(niu_q);
    end
    if (kind_i == KIND_WRITE) begin
      item_o.op = (lock_ok && node_ok) ? OP_WRITE : OP_NOP;
    end else begin
      item_o.op = lock_ok ? OP_ARB : OP_NOP;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

FILE: rtl/owlarb_queue.sv
`default_nettype none

module owlarb_queue import owlarb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  output logic   full_o,
  input  logic   pop_i,
  output qhead_t head_o
);

  item_t             ent_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    r = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign full_o       = cnt_q == QCNT_W'(QDEPTH);
  assign head_o.valid = cnt_q != '0;
  assign head_o.item  = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/owlarb_back.sv
`default_nettype none

module owlarb_back import owlarb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qhead_t               head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 granted_o,
  output logic [NODE_ID_W-1:0] winner_node_o,
  output logic                 held_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_REDUCE = 5'b00100,
    S_GRANT  = 5'b01000,
    S_DONE   = 5'b10000
  } bstate_e;

  typedef struct packed {
    logic                 granted;
    logic [NODE_ID_W-1:0] winner;
    logic                 held;
  } res_t;

  bstate_e state_q, state_d;
  item_t   cur_q, cur_d;
  res_t    res_q, res_d;
  res_t    out_q;
  logic    out_valid_q, out_valid_d;
  logic    out_load;
  logic [LVL_W-1:0] lvl_q, lvl_d;

  // Row-wide stores: one word holds every node slot of one lock.
  logic [NODE_SLOTS-1:0][STATE_W-1:0] st_mem  [MAX_LOCKS];
  logic [NODE_SLOTS-1:0][SEQ_W-1:0]   seq_mem [MAX_LOCKS];
  logic [NODE_SLOTS-1:0][STATE_W-1:0] st_rd_q;
  logic [NODE_SLOTS-1:0][SEQ_W-1:0]   seq_rd_q;
  logic [MAX_LOCKS-1:0]               row_vld_q;
  logic                               rd_vld_q;

  logic                               rd_en;
  logic                               st_we;
  logic                               seq_we;
  logic                               st_full;
  logic [ROW_W-1:0]                   st_row;
  logic [LANE_W-1:0]                  st_lane;
  logic [STATE_W-1:0]                 st_val;
  logic [NODE_SLOTS-1:0]              st_mask;
  logic [NODE_SLOTS-1:0][STATE_W-1:0] st_wdata;

  logic [NODE_SLOTS-1:0] lane_locked;
  logic [NODE_SLOTS-1:0] lane_waiting;

  logic              cand_v_q   [CAND_N];
  logic [SEQ_W-1:0]  cand_seq_q [CAND_N];
  logic [LANE_W-1:0] cand_idx_q [CAND_N];
  logic              red_v      [CAND_N];
  logic [SEQ_W-1:0]  red_seq    [CAND_N];
  logic [LANE_W-1:0] red_idx    [CAND_N];
  logic              pick_l;

  // A row that was never written reads as all idle.
  always_comb begin
    for (int i = 0; i < NODE_SLOTS; i++) begin
      lane_locked[i]  = rd_vld_q && cur_q.span[i] && (st_rd_q[i] == ST_LOCKED);
      lane_waiting[i] = rd_vld_q && cur_q.span[i] && (st_rd_q[i] == ST_WAITING);
    end
  end

  // One level of the pairwise minimum tree; ties keep the left, lower node.
  always_comb begin
    pick_l = 1'b0;
    for (int i = 0; i < CAND_N; i++) begin
      red_v[i]   = 1'b0;
      red_seq[i] = cand_seq_q[i];
      red_idx[i] = cand_idx_q[i];
    end
    for (int i = 0; i < CAND_N / 2; i++) begin
      pick_l     = cand_v_q[2*i] &&
                   (!cand_v_q[2*i+1] || (cand_seq_q[2*i] <= cand_seq_q[2*i+1]));
      red_v[i]   = cand_v_q[2*i] || cand_v_q[2*i+1];
      red_seq[i] = pick_l ? cand_seq_q[2*i] : cand_seq_q[2*i+1];
      red_idx[i] = pick_l ? cand_idx_q[2*i] : cand_idx_q[2*i+1];
    end
  end

  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    res_d    = res_q;
    lvl_d    = lvl_q;
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    st_we    = 1'b0;
    seq_we   = 1'b0;
    st_full  = 1'b0;
    st_row   = cur_q.row;
    st_lane  = cur_q.lane;
    st_val   = ST_LOCKED;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          cur_d = head_i.item;
          res_d = '0;
          unique case (head_i.item.op)
            OP_WRITE: begin
              st_we   = 1'b1;
              seq_we  = 1'b1;
              st_row  = head_i.item.row;
              st_lane = head_i.item.lane;
              st_val  = head_i.item.new_state;
              // First write to a row also clears its other slots to idle.
              st_full = !row_vld_q[head_i.item.row];
              state_d = S_DONE;
            end
            OP_ARB: begin
              rd_en   = 1'b1;
              state_d = S_LOAD;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_LOAD: begin
        if (|lane_locked) begin
          res_d.held = 1'b1;
          state_d    = S_DONE;
        end else begin
          lvl_d   = '0;
          state_d = S_REDUCE;
        end
      end
      S_REDUCE: begin
        lvl_d = lvl_q + 1'b1;
        if (lvl_q == LVL_W'(LANE_W - 1)) begin
          state_d = S_GRANT;
        end
      end
      S_GRANT: begin
        st_we         = cand_v_q[0];
        st_lane       = cand_idx_q[0];
        st_val        = ST_LOCKED;
        res_d.granted = cand_v_q[0];
        res_d.winner  = cand_v_q[0] ? NODE_ID_W'(cand_idx_q[0]) : '0;
        res_d.held    = 1'b0;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < NODE_SLOTS; i++) begin
      st_mask[i]  = st_full || (LANE_W'(i) == st_lane);
      st_wdata[i] = (LANE_W'(i) == st_lane) ? st_val : ST_IDLE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
      if (st_we) begin
        row_vld_q[st_row] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= row_vld_q[head_i.item.row];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
    if (state_q == S_LOAD) begin
      for (int i = 0; i < CAND_N; i++) begin
        cand_v_q[i]   <= (i < NODE_SLOTS) ? lane_waiting[i] : 1'b0;
        cand_seq_q[i] <= (i < NODE_SLOTS) ? seq_rd_q[i] : '0;
        cand_idx_q[i] <= LANE_W'(i);
      end
    end else if (state_q == S_REDUCE) begin
      for (int i = 0; i < CAND_N; i++) begin
        cand_v_q[i]   <= red_v[i];
        cand_seq_q[i] <= red_seq[i];
        cand_idx_q[i] <= red_idx[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      for (int i = 0; i < NODE_SLOTS; i++) begin
        if (st_mask[i]) begin
          st_mem[st_row][i] <= st_wdata[i];
        end
      end
    end
    if (seq_we) begin
      seq_mem[st_row][st_lane] <= head_i.item.seq;
    end
    if (rd_en) begin
      st_rd_q  <= st_mem[head_i.item.row];
      seq_rd_q <= seq_mem[head_i.item.row];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign granted_o     = out_q.granted;
  assign winner_node_o = out_q.winner;
  assign held_o        = out_q.held;

  a_no_winner_without_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> winner_node_o == '0)
    else $error("winner reported without a grant");

  a_grant_excludes_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(granted_o && held_o))
    else $error("grant and held raised together");

  a_grant_on_written_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we && state_q == S_GRANT |-> row_vld_q[st_row])
    else $error("grant written to a row never written before");

  a_load_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> $past(rd_en))
    else $error("row word used without a read");

endmodule

`default_nettype wire

FILE: rtl/oldest_waiter_lock_arbiter_core.sv
// Oldest-waiter lock arbiter. Each input word either writes one node slot
// (state and sequence number) of one lock row, or arbitrates one lock row.
// Arbitration grants the waiting node with the smallest sequence number,
// ties to the lower node, unless a slot in the scanned range is locked,
// in which case held is returned. Every input word yields one result word.
// Input and output channels use valid/stall; a word moves when valid is
// high and stall is low. The nodes_in_use register is written through its
// own valid/ready port; ready is always high. The user must write it only
// while the block is idle; the block itself does not enforce this.
// Items go through a two-entry queue into a sequencer that owns the row
// memories, so the input side takes up to two words while results wait.
// The sequencer and its single memory port take one item at a time: a slot
// write is stored and an out-of-range item is skipped, and either is then
// reported; an arbitrate reads its row, loads the candidates, reports held
// if a slot is locked, else reduces the minimum tree level by level, writes
// any grant back and reports the result.
// Reset empties the queue, marks every lock row unwritten (reads as all
// idle) and sets nodes_in_use to 16; no clearing pass is needed.
// A stalled output holds its word and the sequencer waits behind it.
`default_nettype none

module oldest_waiter_lock_arbiter_core import owlarb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [LOCK_ID_W-1:0] lock_id_i,
  input  logic [NODE_ID_W-1:0] node_id_i,
  input  logic [STATE_W-1:0]   new_state_i,
  input  logic [SEQ_W-1:0]     seq_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 granted_o,
  output logic [NODE_ID_W-1:0] winner_node_o,
  output logic                 held_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [NIU_W-1:0]     cfg_nodes_in_use_i
);

  item_t  push_item;
  logic   push;
  logic   q_full;
  logic   pop;
  qhead_t head;

  owlarb_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .lock_id_i          (lock_id_i),
    .node_id_i          (node_id_i),
    .new_state_i        (new_state_i),
    .seq_i              (seq_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_nodes_in_use_i (cfg_nodes_in_use_i),
    .q_full_i           (q_full),
    .push_o             (push),
    .item_o             (push_item)
  );

  owlarb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  owlarb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .granted_o     (granted_o),
    .winner_node_o (winner_node_o),
    .held_o        (held_o)
  );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
module testbench import owlarb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0]  KIND_ARB      = ~KIND_WRITE;
  localparam logic [STATE_W-1:0] ST_SPARE      = 2'd3;
  localparam int                 SETTLE_CYCLES = 16;
  localparam int                 LONG_HOLD     = 300;
  localparam int                 CYCLE_LIMIT   = 500_000;
  localparam int                 PHASE_WORDS   = 160;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [LOCK_ID_W-1:0] lock_id;
    logic [NODE_ID_W-1:0] node_id;
    logic [STATE_W-1:0]   new_state;
    logic [SEQ_W-1:0]     seq;
  } lock_word_t;

  typedef struct packed {
    logic                 granted;
    logic [NODE_ID_W-1:0] winner;
    logic                 held;
  } lock_verdict_t;

  localparam lock_verdict_t NO_GRANT  = '0;
  localparam lock_verdict_t HELD_ONLY = '{1'b0, 4'd0, 1'b1};

  typedef struct packed {
    logic [NIU_W-1:0] width;
    lock_word_t       word;
    logic             typed;
    lock_verdict_t    verdict;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{5'd16, '{KIND_ARB,   6'd0,  4'd0,  ST_IDLE,    32'h0000_0000}, 1'b1, NO_GRANT},
    '{5'd16, '{KIND_WRITE, 6'd63, 4'd15, ST_WAITING, 32'hFFFF_FFFF}, 1'b1, NO_GRANT},
    '{5'd16, '{KIND_WRITE, 6'd63, 4'd0,  ST_WAITING, 32'hFFFF_FFFF}, 1'b1, NO_GRANT},
    '{5'd16, '{KIND_ARB,   6'd63, 4'd0,  ST_IDLE,    32'h0000_0000}, 1'b0, NO_GRANT},
    '{5'd16, '{KIND_ARB,   6'd63, 4'd0,  ST_IDLE,    32'h0000_0000}, 1'b1, HELD_ONLY},
    '{5'd16, '{KIND_WRITE, 6'd63, 4'd0,  ST_IDLE,    32'h0000_0000}, 1'b1, NO_GRANT},
    '{5'd16, '{KIND_ARB,   6'd63, 4'd15, ST_SPARE,   32'hFFFF_FFFF}, 1'b0, NO_GRANT},
    '{5'd16, '{KIND_WRITE, 6'd5,  4'd3,  ST_SPARE,   32'h0000_0000}, 1'b1, NO_GRANT},
    '{5'd16, '{KIND_WRITE, 6'd5,  4'd7,  ST_WAITING, 32'h8000_0000}, 1'b1, NO_GRANT},
    '{5'd16, '{KIND_WRITE, 6'd5,  4'd9,  ST_WAITING, 32'h7FFF_FFFF}, 1'b1, NO_GRANT},
    '{5'd16, '{KIND_WRITE, 6'd5,  4'd1,  ST_WAITING, 32'hFFFF_FFFE}, 1'b1, NO_GRANT},
    '{5'd16, '{KIND_ARB,   6'd5,  4'd0,  ST_IDLE,    32'h0000_0000}, 1'b0, NO_GRANT},
    '{5'd16, '{KIND_ARB,   6'd5,  4'd0,  ST_IDLE,    32'h0000_0000}, 1'b1, HELD_ONLY},
    '{5'd0,  '{KIND_ARB,   6'd5,  4'd0,  ST_IDLE,    32'h0000_0000}, 1'b1, NO_GRANT},
    '{5'd31, '{KIND_ARB,   6'd5,  4'd0,  ST_IDLE,    32'h0000_0000}, 1'b1, HELD_ONLY},
    '{5'd8,  '{KIND_ARB,   6'd5,  4'd0,  ST_IDLE,    32'h0000_0000}, 1'b0, NO_GRANT},
    '{5'd8,  '{KIND_WRITE, 6'd5,  4'd9,  ST_IDLE,    32'h0000_0000}, 1'b1, NO_GRANT},
    '{5'd16, '{KIND_ARB,   6'd5,  4'd0,  ST_IDLE,    32'h0000_0000}, 1'b1, HELD_ONLY},
    '{5'd1,  '{KIND_ARB,   6'd5,  4'd0,  ST_IDLE,    32'h0000_0000}, 1'b1, NO_GRANT},
    '{5'd1,  '{KIND_WRITE, 6'd5,  4'd0,  ST_WAITING, 32'h0000_0000}, 1'b1, NO_GRANT},
    '{5'd1,  '{KIND_ARB,   6'd5,  4'd0,  ST_IDLE,    32'h0000_0000}, 1'b0, NO_GRANT},
    '{5'd16, '{KIND_WRITE, 6'd0,  4'd15, ST_LOCKED,  32'h0000_0000}, 1'b1, NO_GRANT},
    '{5'd16, '{KIND_ARB,   6'd0,  4'd0,  ST_IDLE,    32'h0000_0000}, 1'b1, HELD_ONLY}
  };

  localparam logic [NIU_W-1:0] PHASE_WIDTH [8] = '{5'd16, 5'd5, 5'd17, 5'd1,
                                                   5'd0, 5'd12, 5'd16, 5'd3};
  localparam int SEND_IDLE [4] = '{0, 72, 0, 27};
  localparam int RECV_IDLE [4] = '{0, 0, 72, 27};

  logic                 clk = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [KIND_W-1:0]    kind_i;
  logic [LOCK_ID_W-1:0] lock_id_i;
  logic [NODE_ID_W-1:0] node_id_i;
  logic [STATE_W-1:0]   new_state_i;
  logic [SEQ_W-1:0]     seq_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 granted_o;
  logic [NODE_ID_W-1:0] winner_node_o;
  logic                 held_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [NIU_W-1:0]     cfg_nodes_in_use_i;

  // Shadow of the lock table and the scan width register.
  logic [STATE_W-1:0] slot_state_m [MAX_LOCKS][NODE_SLOTS];
  logic [SEQ_W-1:0]   slot_seq_m [MAX_LOCKS][NODE_SLOTS];
  logic [NIU_W-1:0]   scan_width;

  lock_verdict_t verdicts_due [$];
  int            send_idle_pct;
  int            recv_idle_pct;
  int            hold_requests;
  int            words_sent;
  int            verdicts_checked;
  int            grants_seen;
  int            held_seen;
  int            cfg_writes;
  int            mismatches;
  int            cycle_count;

  always #5 clk = ~clk;

  oldest_waiter_lock_arbiter_core DUT (
    .clk_i              (clk),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .lock_id_i          (lock_id_i),
    .node_id_i          (node_id_i),
    .new_state_i        (new_state_i),
    .seq_i              (seq_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .granted_o          (granted_o),
    .winner_node_o      (winner_node_o),
    .held_o             (held_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_nodes_in_use_i (cfg_nodes_in_use_i)
  );

  // Applies one word to the shadow table and returns the verdict it earns.
  function automatic lock_verdict_t lock_table_step(lock_word_t w);
    lock_verdict_t    v;
    int               span;
    int               best;
    logic             have;
    logic [SEQ_W-1:0] oldest_seq;
    v = NO_GRANT;
    have = 1'b0;
    best = 0;
    oldest_seq = '0;
    if (w.kind == KIND_WRITE) begin
      if (w.lock_id < MAX_LOCKS && w.node_id < NODE_SLOTS) begin
        slot_state_m[w.lock_id][w.node_id] = w.new_state;
        slot_seq_m[w.lock_id][w.node_id] = w.seq;
      end
    end else if (w.lock_id < MAX_LOCKS) begin
      span = (scan_width > NODE_SLOTS) ? NODE_SLOTS : int'(scan_width);
      for (int n = 0; n < span && !v.held; n++) begin
        if (slot_state_m[w.lock_id][n] == ST_LOCKED) begin
          v.held = 1'b1;
        end else if (slot_state_m[w.lock_id][n] == ST_WAITING &&
                     (!have || slot_seq_m[w.lock_id][n] < oldest_seq)) begin
          have = 1'b1;
          best = n;
          oldest_seq = slot_seq_m[w.lock_id][n];
        end
      end
      if (!v.held && have) begin
        slot_state_m[w.lock_id][best] = ST_LOCKED;
        v.granted = 1'b1;
        v.winner = NODE_ID_W'(best);
      end
    end
    return v;
  endfunction

  // Sequence numbers lean toward ties and both ends of the range.
  function automatic logic [SEQ_W-1:0] pick_seq();
    case ($urandom_range(3))
      0: return SEQ_W'($urandom_range(3));
      1: return '1 - SEQ_W'($urandom_range(3));
      default: return $urandom;
    endcase
  endfunction

  task automatic offer_word(lock_word_t w, logic typed, lock_verdict_t typed_verdict);
    lock_verdict_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk) in_valid_i <= 1'b0;
    end
    @(negedge clk);
    in_valid_i  <= 1'b1;
    kind_i      <= w.kind;
    lock_id_i   <= w.lock_id;
    node_id_i   <= w.node_id;
    new_state_i <= w.new_state;
    seq_i       <= w.seq;
    do @(posedge clk); while (in_stall_o);
    predicted = lock_table_step(w);
    verdicts_due.push_back(typed ? typed_verdict : predicted);
    words_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk) in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_scan_width(logic [NIU_W-1:0] width);
    drain_results();
    // Every word yields a result, but give the sequencer time to retire.
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid_i        <= 1'b1;
    cfg_nodes_in_use_i <= width;
    do @(posedge clk); while (!cfg_ready_o);
    scan_width = width;
    cfg_writes++;
    @(negedge clk) cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int words, int hold_at);
    int                   sent;
    int                   span;
    lock_word_t           w;
    logic [LOCK_ID_W-1:0] lk;
    sent = 0;
    while (sent < words) begin
      if (hold_at >= 0 && sent >= hold_at) begin
        hold_requests++;
        hold_at = -1;
      end
      span = (scan_width > NODE_SLOTS) ? NODE_SLOTS : int'(scan_width);
      if ($urandom_range(99) < 75) begin
        // Contention on one lock: a few requests, arbitration, then release.
        lk = ($urandom_range(3) == 0) ? LOCK_ID_W'($urandom) : LOCK_ID_W'($urandom_range(7));
        repeat ($urandom_range(1, 5)) begin
          w.kind      = KIND_WRITE;
          w.lock_id   = lk;
          w.node_id   = (span == 0 || $urandom_range(3) == 0) ?
                        NODE_ID_W'($urandom) : NODE_ID_W'($urandom_range(span - 1));
          w.new_state = ($urandom_range(9) == 0) ? ST_LOCKED : ST_WAITING;
          w.seq       = pick_seq();
          offer_word(w, 1'b0, NO_GRANT);
          sent++;
        end
        repeat ($urandom_range(1, 3)) begin
          w = lock_word_t'({$urandom, $urandom});
          w.kind    = KIND_ARB;
          w.lock_id = lk;
          offer_word(w, 1'b0, NO_GRANT);
          sent++;
        end
        for (int n = 0; n < NODE_SLOTS; n++) begin
          if (slot_state_m[lk][n] == ST_LOCKED && $urandom_range(3) != 0) begin
            w.kind      = KIND_WRITE;
            w.lock_id   = lk;
            w.node_id   = NODE_ID_W'(n);
            w.new_state = ST_IDLE;
            w.seq       = $urandom;
            offer_word(w, 1'b0, NO_GRANT);
            sent++;
          end
        end
      end else begin
        w = lock_word_t'({$urandom, $urandom});
        offer_word(w, 1'b0, NO_GRANT);
        sent++;
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin : receiver
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    lock_verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdicts_due.size() == 0) begin
        $error("unexpected result word: granted %0d winner_node %0d held %0d",
               granted_o, winner_node_o, held_o);
        mismatches++;
      end else begin
        want = verdicts_due.pop_front();
        verdicts_checked++;
        if (want.granted) grants_seen++;
        if (want.held) held_seen++;
        if (granted_o !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, granted_o);
          mismatches++;
        end
        if (winner_node_o !== want.winner) begin
          $error("winner_node: expected %0d, got %0d", want.winner, winner_node_o);
          mismatches++;
        end
        if (held_o !== want.held) begin
          $error("held: expected %0d, got %0d", want.held, held_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results outstanding",
             cycle_count, verdicts_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int applied_width;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    kind_i             = '0;
    lock_id_i          = '0;
    node_id_i          = '0;
    new_state_i        = '0;
    seq_i              = '0;
    cfg_valid_i        = 1'b0;
    cfg_nodes_in_use_i = '0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    hold_requests      = 0;
    words_sent         = 0;
    verdicts_checked   = 0;
    grants_seen        = 0;
    held_seen          = 0;
    cfg_writes         = 0;
    mismatches         = 0;
    scan_width         = NIU_RESET;
    for (int l = 0; l < MAX_LOCKS; l++) begin
      for (int n = 0; n < NODE_SLOTS; n++) begin
        slot_state_m[l][n] = ST_IDLE;
        slot_seq_m[l][n] = '0;
      end
    end
    repeat (7) @(posedge clk);
    @(negedge clk) rst_ni <= 1'b1;

    // The first row always writes the register, even at its reset value.
    applied_width = -1;
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (int'(DIRECTED[r].width) != applied_width) begin
        set_scan_width(DIRECTED[r].width);
        applied_width = DIRECTED[r].width;
      end
      offer_word(DIRECTED[r].word, DIRECTED[r].typed, DIRECTED[r].verdict);
    end

    for (int p = 0; p < 8; p++) begin
      set_scan_width(PHASE_WIDTH[p]);
      send_idle_pct = SEND_IDLE[p % 4];
      recv_idle_pct = RECV_IDLE[p % 4];
      run_random(PHASE_WORDS, (p == 0) ? PHASE_WORDS / 2 : -1);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d words sent, %0d results checked (%0d grants, %0d held) in %0d cycles",
             words_sent, verdicts_checked, grants_seen, held_seen, cycle_count);
    $display("%0d scan width writes, widths 0 to 31 incl. saturation, idle mixes on both sides",
             cfg_writes);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/owlarb_pkg.sv
rtl/owlarb_front.sv
rtl/owlarb_queue.sv
rtl/owlarb_back.sv
rtl/oldest_waiter_lock_arbiter_core.sv
bench/testbench.sv
